// ===== src/spe_pkg.sv =====
// shared types and constants for the stepper profile pulse engine
`timescale 1ns / 1ps
`default_nettype none

package spe_pkg;

  // default profile memory depth
  localparam int PROFILE_DEPTH_DEF = 1024;

  // field widths
  localparam int KIND_W   = 3;
  localparam int ENTRY_W  = 10;
  localparam int PERIOD_W = 16;
  localparam int POS_W    = 32;
  localparam int IDX_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ESTOP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SETPOS = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAX = 2'd2;

  // input transaction payload
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [ENTRY_W-1:0]      entry_index;
    logic [PERIOD_W-1:0]     entry_value;
    logic                    load_last;
    logic signed [POS_W-1:0] position_value;
  } spe_in_t;

  // output transaction payload
  typedef struct packed {
    logic                    step_level;
    logic signed [POS_W-1:0] position;
    logic                    running;
    logic                    done_res;
    logic                    fault;
    logic [IDX_W-1:0]        profile_index;
  } spe_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic fetch_commit;
  } spe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fetch_req;
    logic out_busy;
  } spe_status_t;

endpackage

`default_nettype wire

// ===== src/stepper_profile_pulse_engine.sv =====
// top level of the stepper profile pulse engine
//
// Step-pulse generator for one stepper channel driven by a profile memory of
// period words. Input transactions (in_valid / in_stall, payload in_data) load
// profile entries, start, stop, emergency stop, tick the timer or set the
// position. Each input transaction produces exactly one output transaction
// (out_valid / out_stall, payload out_data) with the channel state after it.
// The result is in the output register at the edge after acceptance. Most
// items are taken one per cycle unless stalled. A start of a loaded profile,
// and a tick that ends a step and moves to the next profile entry, stall the
// input for a fetch state that loads the next period word from the registered
// read port of the profile memory. Configuration is written through
// cfg_write / cfg_index / cfg_data while the channel is quiet; the user must
// keep to this, the block does not enforce it. Reset (rst, synchronous)
// returns the channel to idle with an empty profile; the profile memory
// itself is not cleared. A stalled result holds out_data and raises in_stall.
`timescale 1ns / 1ps
`default_nettype none

module stepper_profile_pulse_engine #(
  parameter int PROFILE_DEPTH = spe_pkg::PROFILE_DEPTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  spe_pkg::spe_in_t               in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output spe_pkg::spe_out_t              out_data,
  input  wire                            cfg_write,
  input  wire [spe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [spe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spe_pkg::*;

  spe_cmd_t    cmd;
  spe_status_t status;

  // sequencing
  spe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // channel state and profile memory
  spe_datapath #(
    .PROFILE_DEPTH (PROFILE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ===== src/spe_ctrl.sv =====
// controller for the stepper profile pulse engine: accept and profile fetch sequencing
`timescale 1ns / 1ps
`default_nettype none

module spe_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  spe_pkg::spe_status_t status,
  output spe_pkg::spe_cmd_t    cmd
);
  import spe_pkg::*;

  typedef enum logic [1:0] {
    ST_READY = 2'b01,
    ST_FETCH = 2'b10
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // stall while a period fetch completes or the output register is full
  assign in_stall = (state != ST_READY) || status.out_busy;

  assign cmd.accept       = in_valid && !in_stall;
  assign cmd.fetch_commit = (state == ST_FETCH);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_READY: begin
        if (cmd.accept && status.fetch_req) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_READY;
      end
      default: begin
        state_next = ST_READY;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/spe_datapath.sv =====
// datapath for the stepper profile pulse engine: channel state, profile memory, output register
`timescale 1ns / 1ps
`default_nettype none

module spe_datapath #(
  parameter int PROFILE_DEPTH = spe_pkg::PROFILE_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  spe_pkg::spe_in_t                   in_data,
  input  spe_pkg::spe_cmd_t                  cmd,
  output spe_pkg::spe_status_t               status,
  output logic                               out_valid,
  input  wire                                out_stall,
  output spe_pkg::spe_out_t                  out_data,
  input  wire                                cfg_write,
  input  wire [spe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [spe_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import spe_pkg::*;

  localparam int AW  = $clog2(PROFILE_DEPTH);
  localparam int RXW = (AW > IDX_W) ? AW : IDX_W;
  localparam int WXW = (AW > ENTRY_W) ? AW : ENTRY_W;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_RUN   = 4'b0010,
    MODE_DONE  = 4'b0100,
    MODE_ERROR = 4'b1000
  } mode_t;

  // configuration registers
  logic                step_direction;
  logic [PERIOD_W-1:0] period_min;
  logic [PERIOD_W-1:0] period_max;

  // channel state
  logic [IDX_W-1:0]        profile_length, profile_length_next;
  logic [IDX_W-1:0]        read_index, read_index_next;
  logic [PERIOD_W-1:0]     active_period;
  logic [PERIOD_W-1:0]     tick_count, tick_count_next;
  logic                    pulse_phase, pulse_phase_next;
  logic signed [POS_W-1:0] step_position, step_position_next;
  mode_t                   channel_mode, channel_mode_next;
  logic                    done_mark, done_mark_next;
  logic                    error_mark, error_mark_next;

  // profile memory and its ports
  logic [PERIOD_W-1:0] profile_store [PROFILE_DEPTH];
  logic [PERIOD_W-1:0] rd_data;
  logic [IDX_W-1:0]    fetch_idx;
  logic [RXW-1:0]      fetch_idx_ext;
  logic [AW-1:0]       rd_addr;
  logic [WXW-1:0]      wr_idx_ext;
  logic [AW-1:0]       wr_addr;
  logic                load_ok;
  logic                load_en;
  logic                fetch_req;
  logic [PERIOD_W-1:0] clamped;
  logic [IDX_W-1:0]    step_next_idx;

  assign fetch_idx_ext = RXW'(fetch_idx);
  assign rd_addr       = fetch_idx_ext[AW-1:0];
  assign wr_idx_ext    = WXW'(in_data.entry_index);
  assign wr_addr       = wr_idx_ext[AW-1:0];
  assign load_ok       = (32'(in_data.entry_index) < 32'(PROFILE_DEPTH));
  assign step_next_idx = read_index + IDX_W'(1);

  // clamp of an incoming period word
  always_comb begin
    if (in_data.entry_value < period_min) begin
      clamped = period_min;
    end else if (in_data.entry_value > period_max) begin
      clamped = period_max;
    end else begin
      clamped = in_data.entry_value;
    end
  end

  // next channel state for the presented item
  always_comb begin
    profile_length_next = profile_length;
    read_index_next     = read_index;
    tick_count_next     = tick_count;
    pulse_phase_next    = pulse_phase;
    step_position_next  = step_position;
    channel_mode_next   = channel_mode;
    done_mark_next      = done_mark;
    error_mark_next     = error_mark;
    fetch_req           = 1'b0;
    fetch_idx           = '0;
    load_en             = 1'b0;
    case (in_data.kind)
      KIND_LOAD: begin
        if (load_ok) begin
          load_en = 1'b1;
          if (in_data.load_last) begin
            profile_length_next = IDX_W'(in_data.entry_index) + IDX_W'(1);
          end
          read_index_next   = '0;
          channel_mode_next = MODE_IDLE;
          done_mark_next    = 1'b0;
          error_mark_next   = 1'b0;
        end
      end
      KIND_START: begin
        if (profile_length == '0) begin
          error_mark_next   = 1'b1;
          channel_mode_next = MODE_ERROR;
        end else begin
          read_index_next   = '0;
          done_mark_next    = 1'b0;
          error_mark_next   = 1'b0;
          pulse_phase_next  = 1'b0;
          channel_mode_next = MODE_RUN;
          tick_count_next   = '0;
          fetch_req         = 1'b1;
        end
      end
      KIND_STOP: begin
        channel_mode_next = MODE_IDLE;
        done_mark_next    = 1'b1;
      end
      KIND_ESTOP: begin
        channel_mode_next = MODE_ERROR;
        error_mark_next   = 1'b1;
        done_mark_next    = 1'b0;
      end
      KIND_TICK: begin
        if (channel_mode == MODE_RUN) begin
          if (tick_count < active_period) begin
            tick_count_next = tick_count + PERIOD_W'(1);
          end else begin
            tick_count_next = '0;
            if (!pulse_phase) begin
              pulse_phase_next = 1'b1;
            end else begin
              // falling edge: one step and the next profile entry
              pulse_phase_next = 1'b0;
              if (step_direction) begin
                step_position_next = step_position + POS_W'(1);
              end else begin
                step_position_next = step_position - POS_W'(1);
              end
              read_index_next = step_next_idx;
              if (step_next_idx >= profile_length) begin
                channel_mode_next = MODE_DONE;
                done_mark_next    = 1'b1;
              end else begin
                fetch_req = 1'b1;
                fetch_idx = step_next_idx;
              end
            end
          end
        end
      end
      KIND_SETPOS: begin
        step_position_next = in_data.position_value;
      end
      default: begin
      end
    endcase
  end

  assign status.fetch_req = fetch_req;
  assign status.out_busy  = out_valid && out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_direction <= 1'b0;
      period_min     <= PERIOD_W'(1);
      period_max     <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIRECTION:  step_direction <= cfg_data[0];
        CFG_PERIOD_MIN: period_min     <= cfg_data[PERIOD_W-1:0];
        CFG_PERIOD_MAX: period_max     <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // profile memory write port
  always_ff @(posedge clk) begin
    if (cmd.accept && load_en) begin
      profile_store[wr_addr] <= clamped;
    end
  end

  // profile memory read port, registered
  always_ff @(posedge clk) begin
    if (cmd.accept && fetch_req) begin
      rd_data <= profile_store[rd_addr];
    end
  end

  // channel state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      profile_length <= '0;
      read_index     <= '0;
      tick_count     <= '0;
      pulse_phase    <= 1'b0;
      step_position  <= '0;
      channel_mode   <= MODE_IDLE;
      done_mark      <= 1'b0;
      error_mark     <= 1'b0;
    end else if (cmd.accept) begin
      profile_length <= profile_length_next;
      read_index     <= read_index_next;
      tick_count     <= tick_count_next;
      pulse_phase    <= pulse_phase_next;
      step_position  <= step_position_next;
      channel_mode   <= channel_mode_next;
      done_mark      <= done_mark_next;
      error_mark     <= error_mark_next;
    end
  end

  // active period follows the fetched entry
  always_ff @(posedge clk) begin
    if (rst) begin
      active_period <= '1;
    end else if (cmd.fetch_commit) begin
      active_period <= rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_data.step_level    <= pulse_phase_next;
      out_data.position      <= step_position_next;
      out_data.running       <= (channel_mode_next == MODE_RUN);
      out_data.done_res      <= done_mark_next;
      out_data.fault         <= error_mark_next;
      out_data.profile_index <= read_index_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/spe_checker.sv =====
// port-level checks for the stepper profile pulse engine
`timescale 1ns / 1ps
`default_nettype none

module spe_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   in_valid,
  input wire                   in_stall,
  input wire                   out_valid,
  input wire                   out_stall,
  input spe_pkg::spe_out_t     out_data
);
  import spe_pkg::*;

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // every accepted input yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted input without result");

  // running never coexists with the fault flag
  a_run_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.running && out_data.fault))
    else $error("running and fault both set");

  // running never coexists with the done flag
  a_run_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.running && out_data.done_res))
    else $error("running and done both set");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind stepper_profile_pulse_engine spe_checker u_spe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
